// File: rtl/core/swish_pkg.sv
// Shared constants, widths and helper functions for the Swish activation unit.
`default_nettype none

package swish_pkg;

	// Data and configuration widths
	localparam int DATA_W = 16;
	localparam int BETA_W = 16;
	localparam logic [BETA_W-1:0] BETA_RESET = 16'd4096;

	// beta * x is Q20; clamped argument covers [-8, 8)
	localparam int Z_FRAC = 20;
	localparam int Z_W    = Z_FRAC + 4;
	localparam int PROD_W = DATA_W + BETA_W + 1;

	// Sigmoid bins, power of two depth
	localparam int SIG_DEPTH = 256;
	localparam int IDX_W     = $clog2(SIG_DEPTH);

	// Sigmoid output Q16 in [0, 1.0]
	localparam int S_W = 17;
	localparam logic [S_W-1:0] S_ONE = 17'h10000;

	// Intermediate widths
	localparam int T_W   = 31;
	localparam int XS_W  = DATA_W + S_W + 1;
	localparam int ZT_W  = Z_W + T_W + 1;
	localparam int D_W   = 21;
	localparam int GD_W  = DATA_W + D_W;
	localparam int SAT_W = 40;

	// Rounding offsets for half away from zero
	localparam logic [63:0] HALF_Q16 = 64'd1 << 15;
	localparam logic [63:0] HALF_Q36 = 64'd1 << 35;

	// Register stages from input to output register
	localparam int PIPE_STAGES = 7;

	// Piecewise-linear sigmoid evaluated at the centre of bin idx
	function automatic logic [S_W-1:0] sig_lookup(input logic [IDX_W-1:0] idx);
		longint c;
		longint a;
		longint s;
		c = (((2 * longint'(idx)) + 1) <<< (Z_FRAC + 3)) / SIG_DEPTH
			- (longint'(1) <<< (Z_FRAC + 3));
		a = (c < 0) ? -c : c;
		if (a >= (longint'(5) <<< Z_FRAC)) begin
			s = 65536;
		end else if (a >= 2490368) begin
			s = (a >>> 9) + 55296;
		end else if (a >= (longint'(1) <<< Z_FRAC)) begin
			s = (a >>> 7) + 40960;
		end else begin
			s = (a >>> 6) + 32768;
		end
		if (c < 0) begin
			s = 65536 - s;
		end
		return s[S_W-1:0];
	endfunction

	// Clamp a wide signed value to the data range
	function automatic logic [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
		lo = -hi - SAT_W'(1);
		if (v > hi) begin
			return hi[DATA_W-1:0];
		end else if (v < lo) begin
			return lo[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/swish_activation_fwd_bwd_unit.sv
// Swish activation unit: forward output and backward gradient, seven-stage pipeline.
`default_nettype none

// Streams one element per beat: forward mode returns x*sigmoid(beta*x), backward mode
// returns g*(s + beta*x*s*(1-s)), all in signed Q8.8 with rounding and saturation; the
// sigmoid is a piecewise-linear curve sampled at 256 bin centres over [-8, 8). There are
// seven register stages. Unless the output stalls, one element is taken every cycle and
// the pipeline holds up to seven in flight. The stages follow the arithmetic chain
// (beta*x, table, x*s and s*(1-s), z*t, rounding, g*d, saturation); stages one, four and
// six hold one multiplier each, stage three holds x*s and s*(1-s) side by side. A stall on
// the output collapses bubbles before it stops the input. beta (unsigned Q4.12, reset 1.0)
// is written through the cfg channel, which is always ready; write it only while the
// pipeline is empty.

module swish_activation_fwd_bwd_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic        [swish_pkg::BETA_W-1:0]  cfg_data,
	// input beats
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 mode,
	input  wire logic signed [swish_pkg::DATA_W-1:0]  x_value,
	input  wire logic signed [swish_pkg::DATA_W-1:0]  grad_in,
	input  wire logic                                 last_in,
	// output beats
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [swish_pkg::DATA_W-1:0]       result_value,
	output logic                                      last_out
);

	localparam int NS = swish_pkg::PIPE_STAGES;
	localparam int DW = swish_pkg::DATA_W;

	logic [swish_pkg::BETA_W-1:0] beta_q;
	logic [NS:1]                  vld_q;
	logic [NS+1:1]                rdy;
	logic [NS:1]                  ld;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= swish_pkg::BETA_RESET;
		end else if (cfg_valid) begin
			beta_q <= cfg_data;
		end
	end

	// Stage handshake: a stage takes data when empty or when it drains downstream
	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		ld[1] = rdy[1] && in_valid;
		for (int k = 2; k <= NS; k++) begin
			ld[k] = rdy[k] && vld_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready = rdy[1];

	// ---------------- stage 1: z = beta * x ----------------
	logic signed [swish_pkg::PROD_W-1:0] z_prod;
	logic signed [swish_pkg::PROD_W-1:0] z_s1;
	logic signed [DW-1:0]                x_s1, g_s1;
	logic                                mode_s1, last_s1;

	assign z_prod = $signed({1'b0, beta_q}) * x_value;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			z_s1    <= z_prod;
			x_s1    <= x_value;
			g_s1    <= grad_in;
			mode_s1 <= mode;
			last_s1 <= last_in;
		end
	end

	// ---------------- stage 2: clamp and sigmoid lookup ----------------
	logic signed [swish_pkg::Z_W-1:0]    zc;
	logic [swish_pkg::Z_W-1:0]           zoff;
	logic [swish_pkg::PROD_W-swish_pkg::Z_W:0] z_hi;
	logic signed [swish_pkg::Z_W-1:0]    zc_s2;
	logic [swish_pkg::S_W-1:0]           s_lut, s_s2;
	logic signed [DW-1:0]                x_s2, g_s2;
	logic                                mode_s2, last_s2;

	always_comb begin
		z_hi = z_s1[swish_pkg::PROD_W-1:swish_pkg::Z_W-1];
		if ((&z_hi) || !(|z_hi)) begin
			zc = z_s1[swish_pkg::Z_W-1:0];
		end else if (z_s1[swish_pkg::PROD_W-1]) begin
			zc = {1'b1, {(swish_pkg::Z_W-1){1'b0}}};
		end else begin
			zc = {1'b0, {(swish_pkg::Z_W-1){1'b1}}};
		end
		// offset binary: zc + 8.0, bin index is its top bits
		zoff  = {~zc[swish_pkg::Z_W-1], zc[swish_pkg::Z_W-2:0]};
		s_lut = swish_pkg::sig_lookup(zoff[swish_pkg::Z_W-1 -: swish_pkg::IDX_W]);
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			zc_s2   <= zc;
			s_s2    <= s_lut;
			x_s2    <= x_s1;
			g_s2    <= g_s1;
			mode_s2 <= mode_s1;
			last_s2 <= last_s1;
		end
	end

	// ---------------- stage 3: x*s and s*(1-s) ----------------
	logic signed [swish_pkg::XS_W-1:0]   xs_prod, xs_s3;
	logic [swish_pkg::S_W-1:0]           s_cmp;
	logic [2*swish_pkg::S_W-1:0]         t_full;
	logic [swish_pkg::T_W-1:0]           t_s3;
	logic signed [swish_pkg::Z_W-1:0]    zc_s3;
	logic [swish_pkg::S_W-1:0]           s_s3;
	logic signed [DW-1:0]                g_s3;
	logic                                mode_s3, last_s3;

	assign xs_prod = x_s2 * $signed({1'b0, s_s2});
	assign s_cmp   = swish_pkg::S_ONE - s_s2;
	assign t_full  = {{swish_pkg::S_W{1'b0}}, s_s2} * {{swish_pkg::S_W{1'b0}}, s_cmp};

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			xs_s3   <= xs_prod;
			t_s3    <= t_full[swish_pkg::T_W-1:0];
			zc_s3   <= zc_s2;
			s_s3    <= s_s2;
			g_s3    <= g_s2;
			mode_s3 <= mode_s2;
			last_s3 <= last_s2;
		end
	end

	// ---------------- stage 4: z*t, forward result rounded ----------------
	logic signed [swish_pkg::ZT_W-1:0]   zt_prod, zt_s4;
	logic signed [swish_pkg::XS_W:0]     xs_sum;
	logic [swish_pkg::XS_W:0]            xs_half;
	logic [DW-1:0]                       fwd_res, fwd_s4;
	logic [swish_pkg::S_W-1:0]           s_s4;
	logic signed [DW-1:0]                g_s4;
	logic                                mode_s4, last_s4;

	assign zt_prod = zc_s3 * $signed({1'b0, t_s3});

	always_comb begin
		xs_half = xs_s3[swish_pkg::XS_W-1] ?
			(swish_pkg::HALF_Q16[swish_pkg::XS_W:0] - 1'b1) :
			swish_pkg::HALF_Q16[swish_pkg::XS_W:0];
		xs_sum  = {xs_s3[swish_pkg::XS_W-1], xs_s3} + $signed(xs_half);
		fwd_res = swish_pkg::sat_data({{(swish_pkg::SAT_W - swish_pkg::XS_W + 15)
			{xs_sum[swish_pkg::XS_W]}}, xs_sum[swish_pkg::XS_W:16]});
	end

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			zt_s4   <= zt_prod;
			fwd_s4  <= fwd_res;
			s_s4    <= s_s3;
			g_s4    <= g_s3;
			mode_s4 <= mode_s3;
			last_s4 <= last_s3;
		end
	end

	// ---------------- stage 5: derivative d = s + round(z*t) ----------------
	logic signed [swish_pkg::ZT_W:0]     zt_sum;
	logic [swish_pkg::ZT_W:0]            zt_half;
	logic signed [swish_pkg::D_W-1:0]    d_val, d_s5;
	logic [DW-1:0]                       fwd_s5;
	logic signed [DW-1:0]                g_s5;
	logic                                mode_s5, last_s5;

	always_comb begin
		zt_half = zt_s4[swish_pkg::ZT_W-1] ?
			(swish_pkg::HALF_Q36[swish_pkg::ZT_W:0] - 1'b1) :
			swish_pkg::HALF_Q36[swish_pkg::ZT_W:0];
		zt_sum  = {zt_s4[swish_pkg::ZT_W-1], zt_s4} + $signed(zt_half);
		d_val   = $signed(zt_sum[swish_pkg::ZT_W:36])
			+ $signed({{(swish_pkg::D_W - swish_pkg::S_W){1'b0}}, s_s4});
	end

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			d_s5    <= d_val;
			fwd_s5  <= fwd_s4;
			g_s5    <= g_s4;
			mode_s5 <= mode_s4;
			last_s5 <= last_s4;
		end
	end

	// ---------------- stage 6: g * d ----------------
	logic signed [swish_pkg::GD_W-1:0]   gd_prod, gd_s6;
	logic [DW-1:0]                       fwd_s6;
	logic                                mode_s6, last_s6;

	assign gd_prod = g_s5 * d_s5;

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			gd_s6   <= gd_prod;
			fwd_s6  <= fwd_s5;
			mode_s6 <= mode_s5;
			last_s6 <= last_s5;
		end
	end

	// ---------------- stage 7: round, saturate, select ----------------
	logic signed [swish_pkg::GD_W:0]     gd_sum;
	logic [swish_pkg::GD_W:0]            gd_half;
	logic [DW-1:0]                       bwd_res;
	logic [DW-1:0]                       result_s7;
	logic                                last_s7;

	always_comb begin
		gd_half = gd_s6[swish_pkg::GD_W-1] ?
			(swish_pkg::HALF_Q16[swish_pkg::GD_W:0] - 1'b1) :
			swish_pkg::HALF_Q16[swish_pkg::GD_W:0];
		gd_sum  = {gd_s6[swish_pkg::GD_W-1], gd_s6} + $signed(gd_half);
		bwd_res = swish_pkg::sat_data({{(swish_pkg::SAT_W - swish_pkg::GD_W + 15)
			{gd_sum[swish_pkg::GD_W]}}, gd_sum[swish_pkg::GD_W:16]});
	end

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			result_s7 <= mode_s6 ? bwd_res : fwd_s6;
			last_s7   <= last_s6;
		end
	end

	assign out_valid    = vld_q[NS];
	assign result_value = $signed(result_s7);
	assign last_out     = last_s7;

endmodule

`default_nettype wire

// File: rtl/core/swish_checker.sv
// Port-level checker for the Swish activation unit, with its bind.
`default_nettype none

module swish_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                cfg_ready,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [swish_pkg::DATA_W-1:0] result_value,
	input wire logic                                last_out
);

	logic [3:0] cnt_q;

	// Beats in flight: accepted inputs minus delivered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {3'b0, in_valid && in_ready} - {3'b0, out_valid && out_ready};
		end
	end

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(last_out))
		else $error("output beat changed while stalled");

	// No result without an input behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 4'd0)
		else $error("result beat with nothing in flight");

	// Occupancy never exceeds the pipeline depth
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(swish_pkg::PIPE_STAGES))
		else $error("more beats in flight than stages");

	// Input back-pressure only when the output is stalled
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && cfg_ready)
		else $error("input stalled while output drains");

endmodule

bind swish_activation_fwd_bwd_unit swish_checker u_swish_checker (.*);

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the Swish activation unit, forward and backward modes.
`timescale 1ns / 1ps

module tb;

	localparam int DW = swish_pkg::DATA_W;
	localparam int RUN_LIMIT = 500000;
	localparam int PHASE_BEATS = 132;
	localparam int REPORT_MAX = 10;

	localparam logic MODE_FWD = 1'b0;
	localparam logic MODE_BWD = 1'b1;

	// Fixed-point constants of the sigmoid curve (argument Q20, output Q16)
	localparam longint ARG_LIMIT  = longint'(8) <<< swish_pkg::Z_FRAC;
	localparam longint KNEE_OUTER = longint'(5) <<< swish_pkg::Z_FRAC;
	localparam longint KNEE_MID   = 2490368;
	localparam longint KNEE_INNER = longint'(1) <<< swish_pkg::Z_FRAC;
	localparam longint UNIT_Q16   = 65536;

	typedef struct {
		logic signed [DW-1:0] value;
		logic                 last;
	} swish_beat_t;

	typedef struct packed {
		logic                 mode;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] g;
		logic                 last;
		logic                 has_lit;
		logic signed [DW-1:0] lit;
	} probe_row_t;

	// Directed probes at reset beta (1.0); a literal is given where it is obvious
	localparam probe_row_t PROBES [22] = '{
		// zero input, and the clamped ends where sigmoid is exactly 0 or 1
		'{MODE_FWD, 16'sd0,     16'sd0,     1'b0, 1'b1, 16'sd0},
		'{MODE_FWD, 16'sd32767, 16'sh8000,  1'b1, 1'b1, 16'sd32767},
		'{MODE_FWD, 16'sh8000,  16'sd32767, 1'b0, 1'b1, 16'sd0},
		'{MODE_BWD, 16'sd32767, 16'sh8000,  1'b0, 1'b1, 16'sh8000},
		'{MODE_BWD, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 16'sd32767},
		'{MODE_BWD, 16'sh8000,  16'sd32767, 1'b0, 1'b1, 16'sd0},
		// small values and the edges of the clamp window
		'{MODE_FWD, 16'sd1,     16'sd0,     1'b0, 1'b0, 16'sd0},
		'{MODE_FWD, -16'sd1,    16'sd0,     1'b0, 1'b0, 16'sd0},
		'{MODE_FWD, 16'sd256,   16'sd0,     1'b0, 1'b0, 16'sd0},
		'{MODE_FWD, -16'sd256,  16'sd0,     1'b1, 1'b0, 16'sd0},
		'{MODE_FWD, 16'sd2047,  16'sd0,     1'b0, 1'b0, 16'sd0},
		'{MODE_FWD, 16'sd2048,  16'sd0,     1'b0, 1'b0, 16'sd0},
		'{MODE_FWD, -16'sd2048, 16'sd0,     1'b0, 1'b0, 16'sd0},
		'{MODE_FWD, -16'sd2049, 16'sd0,     1'b0, 1'b0, 16'sd0},
		// gradient overshoot near z = 2.4 saturates both ways
		'{MODE_BWD, 16'sd614,   16'sd32767, 1'b0, 1'b0, 16'sd0},
		'{MODE_BWD, 16'sd614,   16'sh8000,  1'b0, 1'b0, 16'sd0},
		'{MODE_BWD, -16'sd614,  16'sd32767, 1'b0, 1'b0, 16'sd0},
		'{MODE_BWD, 16'sd0,     16'sh8000,  1'b0, 1'b0, 16'sd0},
		'{MODE_BWD, 16'sd1000,  16'sd1,     1'b0, 1'b0, 16'sd0},
		// forward ignores the gradient, then backward with negative gradients
		'{MODE_FWD, 16'sd100,   16'sd32767, 1'b0, 1'b0, 16'sd0},
		'{MODE_BWD, -16'sd1,    -16'sd1,    1'b1, 1'b0, 16'sd0},
		'{MODE_BWD, 16'sd600,   -16'sd12345, 1'b0, 1'b0, 16'sd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [15:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic signed [DW-1:0] x_value;
	logic signed [DW-1:0] grad_in;
	logic                 last_in;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [DW-1:0] result_value;
	logic                 last_out;

	// Literal expectation travelling with the current input beat
	logic                 lit_valid;
	logic signed [DW-1:0] lit_value;

	swish_beat_t due_results[$];
	logic [15:0] beta_cfg;
	int          fault_count;
	int          beats_sent;
	int          results_seen;
	int          calm_left;
	int          cycle_count;

	swish_activation_fwd_bwd_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.x_value      (x_value),
		.grad_in      (grad_in),
		.last_in      (last_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.last_out     (last_out)
	);

	always #5 clk = ~clk;

	// Divide by 2^k, rounding half away from zero
	function automatic longint round_away(input longint v, input int k);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) <<< (k - 1))) >>> k;
		return (v < 0) ? -mag : mag;
	endfunction

	// Swish output or input gradient for one element at the given beta
	function automatic logic signed [DW-1:0] swish_fwd_bwd(input logic m,
			input logic signed [DW-1:0] x, input logic signed [DW-1:0] g,
			input logic [15:0] b);
		longint z;
		longint bin;
		longint ctr;
		longint a;
		longint s;
		longint r;
		z = longint'(b) * longint'(x);
		if (z < -ARG_LIMIT) begin
			z = -ARG_LIMIT;
		end
		if (z > ARG_LIMIT - 1) begin
			z = ARG_LIMIT - 1;
		end
		// sigmoid is taken at the centre of the bin holding z
		bin = ((z + ARG_LIMIT) * swish_pkg::SIG_DEPTH) >>> (swish_pkg::Z_FRAC + 4);
		ctr = (((2 * bin + 1) <<< (swish_pkg::Z_FRAC + 3)) / swish_pkg::SIG_DEPTH)
			- ARG_LIMIT;
		a = (ctr < 0) ? -ctr : ctr;
		if (a >= KNEE_OUTER) begin
			s = UNIT_Q16;
		end else if (a >= KNEE_MID) begin
			s = (a >>> 9) + 55296;
		end else if (a >= KNEE_INNER) begin
			s = (a >>> 7) + 40960;
		end else begin
			s = (a >>> 6) + 32768;
		end
		if (ctr < 0) begin
			s = UNIT_Q16 - s;
		end
		if (m == MODE_FWD) begin
			r = round_away(longint'(x) * s, 16);
		end else begin
			r = s + round_away(z * (s * (UNIT_Q16 - s)), 36);
			r = round_away(longint'(g) * r, 16);
		end
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		return r[DW-1:0];
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// One input beat, with an idle gap before it unless in a calm stretch
	task automatic send_beat(input logic m, input logic signed [DW-1:0] xv,
			input logic signed [DW-1:0] gv, input logic lv, input logic hl,
			input logic signed [DW-1:0] lv_lit);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = idle_len();
			if ($urandom_range(0, 19) == 0) begin
				calm_left = $urandom_range(10, 40);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		x_value   <= xv;
		grad_in   <= gv;
		last_in   <= lv;
		lit_valid <= hl;
		lit_value <= lv_lit;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// Hold input until every beat sent has come back, then let the pipe settle
	task automatic wait_empty();
		in_valid <= 1'b0;
		while (results_seen < beats_sent) @(posedge clk);
		repeat (swish_pkg::PIPE_STAGES + 2) @(posedge clk);
	endtask

	task automatic write_beta(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random x: mostly inside the unclamped window for this beta
	function automatic logic signed [DW-1:0] pick_x(input logic [15:0] b);
		int span;
		int pick;
		span = (b == 0) ? 32767 : (8 << 20) / int'(b) + 4;
		if (span > 32767) begin
			span = 32767;
		end
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return DW'(int'($urandom_range(0, 2 * span)) - span);
		end else if (pick < 62) begin
			case ($urandom_range(0, 4))
				0: return 16'sh8000;
				1: return 16'sd32767;
				2: return 16'sd0;
				3: return 16'sd1;
				default: return -16'sd1;
			endcase
		end
		return DW'($urandom());
	endfunction

	function automatic logic signed [DW-1:0] pick_g();
		if ($urandom_range(0, 99) < 85) begin
			return DW'($urandom());
		end
		return ($urandom_range(0, 1) == 1) ? 16'sd32767 : 16'sh8000;
	endfunction

	// Beat monitor: follows config, predicts on input beats, checks output beats
	always @(posedge clk) begin
		swish_beat_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				beta_cfg = cfg_data;
			end
			if (in_valid && in_ready) begin
				want.value = lit_valid ? lit_value
					: swish_fwd_bwd(mode, x_value, grad_in, beta_cfg);
				want.last  = last_in;
				due_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_MAX) begin
						$display("unexpected output beat: result_value %0d last_out %b",
							result_value, last_out);
					end
				end else begin
					want = due_results.pop_front();
					if (result_value !== want.value || last_out !== want.last) begin
						fault_count++;
						if (fault_count <= REPORT_MAX) begin
							$display("mismatch: result_value exp %0d got %0d, last_out exp %b got %b",
								want.value, result_value, want.last, last_out);
						end
					end
				end
			end
		end
	end

	// Sink: random stalls with occasional long ready stretches
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Main sequence
	initial begin
		logic [15:0] phase_beta [8];
		logic [15:0] b;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		mode         = MODE_FWD;
		x_value      = '0;
		grad_in      = '0;
		last_in      = 1'b0;
		lit_valid    = 1'b0;
		lit_value    = '0;
		beta_cfg     = swish_pkg::BETA_RESET;
		fault_count  = 0;
		beats_sent   = 0;
		results_seen = 0;
		calm_left    = 0;
		phase_beta   = '{16'd0, 16'd65535, 16'd1, 16'd2048, 16'd8192, 16'd0, 16'd0, 16'd4096};
		phase_beta[5] = 16'($urandom());
		phase_beta[6] = 16'($urandom());

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed probes at the reset beta
		foreach (PROBES[i]) begin
			send_beat(PROBES[i].mode, PROBES[i].x, PROBES[i].g, PROBES[i].last,
				PROBES[i].has_lit, PROBES[i].lit);
		end

		// random phases, one beta each, with a full drain half way through
		foreach (phase_beta[p]) begin
			b = phase_beta[p];
			wait_empty();
			write_beta(b);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n == PHASE_BEATS / 2) begin
					wait_empty();
				end
				send_beat(logic'($urandom_range(0, 1)), pick_x(b), pick_g(),
					$urandom_range(0, 7) == 0, 1'b0, 16'sd0);
			end
		end

		wait_empty();
		repeat (swish_pkg::PIPE_STAGES + 4) @(posedge clk);
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
